### rtl/core/assert_macros.svh
// Assertion macros for the deframer RTL.
// Included by modules that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/ipd_pkg.sv
// Package for the IPD frame deframer: header characters, match positions,
// result kinds and default parameters. No dependencies.
`default_nettype none

package ipd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LinkW    = 4;
  localparam int unsigned LenW     = 16;
  localparam int unsigned PosW     = 4;
  localparam int unsigned DigCntW  = 3;
  localparam int unsigned MaxDigitsDefault = 5;

  // Header characters
  localparam logic [ByteW-1:0] CharPlus  = 8'h2B;  // '+'
  localparam logic [ByteW-1:0] CharI     = 8'h49;  // 'I'
  localparam logic [ByteW-1:0] CharP     = 8'h50;  // 'P'
  localparam logic [ByteW-1:0] CharD     = 8'h44;  // 'D'
  localparam logic [ByteW-1:0] CharComma = 8'h2C;  // ','
  localparam logic [ByteW-1:0] CharZero  = 8'h30;  // '0'
  localparam logic [ByteW-1:0] CharNine  = 8'h39;  // '9'
  localparam logic [ByteW-1:0] CharColon = 8'h3A;  // ':'

  localparam logic [LinkW-1:0] LinkMax = 4'd9;

  // Match positions
  localparam logic [PosW-1:0] PosHunt    = 4'd0;
  localparam logic [PosW-1:0] PosI       = 4'd1;
  localparam logic [PosW-1:0] PosP       = 4'd2;
  localparam logic [PosW-1:0] PosD       = 4'd3;
  localparam logic [PosW-1:0] PosComma1  = 4'd4;
  localparam logic [PosW-1:0] PosLink    = 4'd5;
  localparam logic [PosW-1:0] PosComma2  = 4'd6;
  localparam logic [PosW-1:0] PosDigits  = 4'd7;
  localparam logic [PosW-1:0] PosPayload = 4'd8;

  // Result kinds (tuser)
  localparam logic KindHeader  = 1'b0;
  localparam logic KindPayload = 1'b1;

endpackage

`default_nettype wire

### rtl/core/ipd_frame_deframer_unit.sv
// IPD frame deframer top level: input register, header/length/payload
// decode, result register. Depends on ipd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Usage
// - Slave stream (s_axis_*): one received byte per transfer in tdata[7:0].
// - Master stream (m_axis_*): one result per transfer. tuser is the kind
//   (0 header, 1 payload byte), tlast marks the final result of a frame.
//   Header results carry the decoded length, payload results the byte.
// - cfg_we_i/cfg_wdata_i write link_id; write only while the block is idle.
// - The block hunts for "+IPD,<link>,", takes up to MAX_DIGITS decimal
//   digits to ':', emits the header, then passes that many payload bytes.
//   Any mismatch, bad digit, too many digits or length over 65535 drops
//   back to hunting without a result. A zero length ends the frame on the
//   header result itself.
// - A byte lands in the input register at its transfer edge; its result is
//   then registered in the result register, from which it is transferred.
//   One byte per cycle while the receiver takes the results; the per-byte
//   decode is a compare, a times-ten add or a decrement.
// - Stall: while the receiver holds a waiting result, one more byte waits in
//   the input register and s_axis_tready_o drops (it follows m_axis_tready_i).
// - Reset: link_id = 0, hunting, both registers empty.
module ipd_frame_deframer_unit #(
  parameter int unsigned MAX_DIGITS = ipd_pkg::MaxDigitsDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // config
  input  wire logic                        cfg_we_i,
  input  wire logic [ipd_pkg::LinkW-1:0]   cfg_wdata_i,     // link_id
  // slave stream
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  wire logic [7:0]                  s_axis_tdata_i,  // [7:0] rx_byte
  // master stream
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  output logic [23:0]                      m_axis_tdata_o,  // [15:0] frame_length,
                                                            // [23:16] payload_byte
  output logic                             m_axis_tuser_o,  // [0] kind
  output logic                             m_axis_tlast_o
);
  import ipd_pkg::*;

  localparam int unsigned AccW = LenW + 4;  // holds 65535*10+9

  logic [LinkW-1:0]   link_q;

  // input register
  logic               in_vld_q;
  logic [ByteW-1:0]   in_byte_q;

  // decode state
  logic [PosW-1:0]    pos_q, pos_d;
  logic [LenW-1:0]    acc_q, acc_d;
  logic [DigCntW-1:0] dcnt_q, dcnt_d;
  logic [LenW-1:0]    rem_q, rem_d;

  // result register
  logic               out_vld_q;
  logic               out_kind_q;
  logic [LenW-1:0]    out_len_q;
  logic [ByteW-1:0]   out_byte_q;
  logic               out_last_q;

  // result of the current byte
  logic               res_vld;
  logic               res_kind;
  logic [LenW-1:0]    res_len;
  logic [ByteW-1:0]   res_byte;
  logic               res_last;

  logic               adv;
  logic               is_digit;
  logic [AccW-1:0]    acc_next;
  logic [ByteW-1:0]   link_char;

  // Byte in the input register moves on when the result slot is free or draining.
  assign adv             = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || adv;

  assign is_digit  = (in_byte_q >= CharZero) && (in_byte_q <= CharNine);
  // acc*10 + digit as two shifts and adds
  assign acc_next  = AccW'({acc_q, 3'b000}) + AccW'({acc_q, 1'b0})
                   + AccW'(in_byte_q - CharZero);
  assign link_char = CharZero + ByteW'(link_q);

  always_comb begin
    pos_d    = pos_q;
    acc_d    = acc_q;
    dcnt_d   = dcnt_q;
    rem_d    = rem_q;
    res_vld  = 1'b0;
    res_kind = KindHeader;
    res_len  = '0;
    res_byte = '0;
    res_last = 1'b0;
    unique case (pos_q)
      PosI, PosP, PosD, PosComma1: begin
        if ((pos_q == PosI      && in_byte_q == CharI) ||
            (pos_q == PosP      && in_byte_q == CharP) ||
            (pos_q == PosD      && in_byte_q == CharD) ||
            (pos_q == PosComma1 && in_byte_q == CharComma)) begin
          pos_d = pos_q + PosW'(1);
        end else begin
          pos_d = PosHunt;
          acc_d = '0; dcnt_d = '0; rem_d = '0;
        end
      end
      PosLink: begin
        if (link_q <= LinkMax && in_byte_q == link_char) begin
          pos_d = PosComma2;
        end else begin
          pos_d = PosHunt;
          acc_d = '0; dcnt_d = '0; rem_d = '0;
        end
      end
      PosComma2: begin
        if (in_byte_q == CharComma) begin
          pos_d  = PosDigits;
          acc_d  = '0;
          dcnt_d = '0;
        end else begin
          pos_d = PosHunt;
          acc_d = '0; dcnt_d = '0; rem_d = '0;
        end
      end
      PosDigits: begin
        if (in_byte_q == CharColon) begin
          res_vld  = 1'b1;
          res_kind = KindHeader;
          res_len  = acc_q;
          res_last = (acc_q == '0);
          if (acc_q == '0) begin
            pos_d = PosHunt;
            acc_d = '0; dcnt_d = '0; rem_d = '0;
          end else begin
            rem_d = acc_q;
            pos_d = PosPayload;
          end
        end else if (!is_digit || 32'(dcnt_q) >= MAX_DIGITS ||
                     acc_next > AccW'(2**LenW - 1)) begin
          pos_d = PosHunt;
          acc_d = '0; dcnt_d = '0; rem_d = '0;
        end else begin
          acc_d  = acc_next[LenW-1:0];
          dcnt_d = dcnt_q + DigCntW'(1);
        end
      end
      PosPayload: begin
        res_vld  = 1'b1;
        res_kind = KindPayload;
        res_byte = in_byte_q;
        res_last = (rem_q <= LenW'(1));
        if (rem_q <= LenW'(1)) begin
          pos_d = PosHunt;
          acc_d = '0; dcnt_d = '0; rem_d = '0;
        end else begin
          rem_d = rem_q - LenW'(1);
        end
      end
      default: begin
        // hunting, and any unused position
        acc_d  = '0;
        dcnt_d = '0;
        rem_d  = '0;
        pos_d  = (in_byte_q == CharPlus) ? PosI : PosHunt;
      end
    endcase
  end

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
    end else if (cfg_we_i) begin
      link_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  // decode state, advanced once per byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= PosHunt;
      acc_q  <= '0;
      dcnt_q <= '0;
      rem_q  <= '0;
    end else if (adv) begin
      pos_q  <= pos_d;
      acc_q  <= acc_d;
      dcnt_q <= dcnt_d;
      rem_q  <= rem_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= res_vld;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_vld) begin
      out_kind_q <= res_kind;
      out_len_q  <= res_len;
      out_byte_q <= res_byte;
      out_last_q <= res_last;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {out_byte_q, out_len_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  // checks
  `ASSERT_NEXT(a_last_hunts, adv && res_vld && res_last, pos_q == PosHunt)
  `ASSERT_IMPL(a_payload_rem, pos_q == PosPayload, rem_q != '0)
  `ASSERT_IMPL(a_hdr_from_digits, adv && res_vld && res_kind == KindHeader,
               pos_q == PosDigits)
  `ASSERT_NEXT(a_held_byte, in_vld_q && !adv, in_vld_q)

endmodule

`default_nettype wire
